// ----- src/wavdec_pkg.sv -----
// shared types and constants of the wav stream decoder
package wavdec_pkg;
    typedef enum logic [3:0] {
        PH_RIFF  = 4'd0,
        PH_RSIZE = 4'd1,
        PH_WAVE  = 4'd2,
        PH_CID   = 4'd3,
        PH_CSIZE = 4'd4,
        PH_FMT   = 4'd5,
        PH_SKIP  = 4'd6,
        PH_PAD   = 4'd7,
        PH_DATA  = 4'd8
    } t_phase;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_RIFF  = 3'd1;
    localparam logic [2:0] ST_BAD_WAVE  = 3'd2;
    localparam logic [2:0] ST_NO_FMT    = 3'd3;
    localparam logic [2:0] ST_BAD_DEPTH = 3'd4;
    localparam logic [2:0] ST_BAD_FMT32 = 3'd5;
    localparam logic [2:0] ST_NO_DATA   = 3'd6;
    localparam logic [2:0] ST_SHORT_FMT = 3'd7;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [15:0] FMT_PCM  = 16'd1;
    localparam logic [15:0] FMT_FLT  = 16'd3;
    localparam logic [15:0] FMT_EXT  = 16'd65534;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
        logic       file_end;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               sample_valid;
        logic               run_last;
        logic [2:0]         status;
        logic [31:0]        rate_hz;
        logic [15:0]        depth_bits;
        logic [15:0]        channel_count;
    } t_out_item;

    // sample conversion request passed from the parser to the converter
    typedef struct packed {
        logic        valid;
        logic        last;
        logic [31:0] gather;
        logic [1:0]  mode;    // 0: 8 bit, 1: 16 bit, 2: 24 bit, 3: 32 bit
        logic        is_float;
    } t_conv_req;
endpackage

// ----- src/wavdec_stream_if.sv -----
// valid/ready channel carrying one payload
interface wavdec_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- src/wavdec_conv.sv -----
// converts a gathered little-endian sample word to signed 16 bit
module wavdec_conv (
    input  wavdec_pkg::t_conv_req i_req,
    output logic [15:0]           o_sample
);
    import wavdec_pkg::*;

    logic [7:0]  exp_f;
    logic [22:0] man_f;
    logic [24:0] mant;      // 1.23 mantissa
    logic [39:0] prod;      // mant * 32767
    logic [15:0] mag;
    logic [5:0]  sh;
    logic        rem_nz;
    logic [15:0] flt;

    always_comb begin
        exp_f    = i_req.gather[30:23];
        man_f    = i_req.gather[22:0];
        mant     = {2'b01, man_f};
        prod     = 40'(mant) * 40'd32767;
        sh       = '0;
        rem_nz   = 1'b0;
        mag      = '0;
        // value = prod * 2^(exp-127-23); product exact, rounding then truncation
        // equals truncation except when rounding carries across an integer
        if (exp_f == 8'hFF && man_f != '0) begin
            mag = '0;
        end else if (exp_f >= 8'd127) begin
            mag = 16'd32767;
        end else if (exp_f < 8'd104) begin
            mag = '0;
        end else begin
            sh = 6'(8'd150 - exp_f);   // 24..46
            // round prod to 24 bits (nearest even) then truncate
            begin
                logic [39:0] rp;
                logic [5:0]  drop;
                logic [39:0] half;
                rp   = prod;
                drop = prod[39] ? 6'd16 : (prod[38] ? 6'd15 : 6'd14);
                half = 40'd1 << (drop - 6'd1);
                rem_nz = ((prod & ((40'd1 << drop) - 40'd1)) > half) ||
                         (((prod & ((40'd1 << drop) - 40'd1)) == half) && prod[drop]);
                rp = (prod >> drop) << drop;
                if (rem_nz) begin
                    rp = rp + (40'd1 << drop);
                end
                mag = 16'(rp >> sh);
            end
        end
        flt = i_req.gather[31] ? 16'(-mag) : mag;
        unique case (i_req.mode)
            2'd0: o_sample = {i_req.gather[7:0] ^ 8'h80, 8'h00};
            2'd1: o_sample = i_req.gather[15:0];
            2'd2: o_sample = i_req.gather[23:8];
            default: o_sample = i_req.is_float ? flt : i_req.gather[31:16];
        endcase
    end
endmodule

// ----- src/wav_pcm_stream_decoder_top.sv -----
// top level of the byte-serial wav decoder
// an accepted byte that completes a sample or ends the run is held in the output register until taken
// throughput: one byte per cycle unless the input stalls; parser state and a result register per stage
// a full output register is replaced in the same cycle it is taken, so the
// input stalls only while a result waits and the sink is not ready
// reset (synchronous, active low) returns the parser to the riff tag phase
module wav_pcm_stream_decoder_top (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    wavdec_stream_if.sink                                      i_in,
    wavdec_stream_if.source                                    o_out
);
    import wavdec_pkg::*;

    // parser state
    t_phase      r_phase, n_phase;
    logic [31:0] r_cnt, n_cnt;
    logic [31:0] r_tag, n_tag;
    logic [31:0] r_clen, n_clen;
    logic [15:0] r_fmt, n_fmt;
    logic [15:0] r_chan, n_chan;
    logic [31:0] r_rate, n_rate;
    logic [15:0] r_depth, n_depth;
    logic        r_fseen, n_fseen;
    logic [31:0] r_gath, n_gath;
    logic [1:0]  r_gidx, n_gidx;
    logic [31:0] r_left, n_left;
    logic        r_done, n_done;
    // samples_left precomputed per depth to avoid a divider
    logic [31:0] len_div;
    logic [1:0]  mode_cur;
    logic        depth_ok;

    // output register
    logic        r_ovalid;
    t_out_item   r_out;
    t_conv_req   conv_req;
    logic [15:0] conv_smp;
    logic        have, finish;
    logic [2:0]  status;
    logic        accept;
    logic [7:0]  b;
    logic [31:0] tag_next, clen_next;

    assign i_in.ready  = !r_ovalid || o_out.ready;
    assign accept      = i_in.valid && i_in.ready;
    assign o_out.valid = r_ovalid;
    assign o_out.payload = r_out;
    assign b = i_in.payload.data_byte;

    wavdec_conv u_conv (.i_req(conv_req), .o_sample(conv_smp));

    always_comb begin
        t_phase      ph;
        logic [31:0] cnt, tag, clen, gath, left, cnt1;
        logic [15:0] fmt, chan, depth;
        logic [31:0] rate;
        logic        fseen, done;
        logic [1:0]  gidx;
        ph = r_phase; cnt = r_cnt; tag = r_tag; clen = r_clen; fmt = r_fmt;
        chan = r_chan; rate = r_rate; depth = r_depth; fseen = r_fseen;
        gath = r_gath; gidx = r_gidx; left = r_left; done = r_done;
        // restart: file start clears everything before parsing this byte
        if (i_in.payload.file_start) begin
            ph = PH_RIFF; cnt = '0; tag = '0; clen = '0; fmt = '0; chan = '0;
            rate = '0; depth = '0; fseen = 1'b0; gath = '0; gidx = '0;
            left = '0; done = 1'b0;
        end
        have = 1'b0; finish = 1'b0; status = ST_OK;
        conv_req = '0;
        cnt1 = cnt + 32'd1;
        tag_next = {tag[23:0], b};
        clen_next = clen | (32'(b) << {cnt[1:0], 3'b000});
        unique case (depth)
            16'd8:  begin mode_cur = 2'd0; depth_ok = 1'b1; len_div = clen_next; end
            16'd16: begin mode_cur = 2'd1; depth_ok = 1'b1; len_div = clen_next >> 1; end
            16'd24: begin
                // exact unsigned divide by three over the full 32-bit range
                mode_cur = 2'd2; depth_ok = 1'b1;
                len_div = 32'((64'(clen_next) * 64'hAAAA_AAAB) >> 33);
            end
            16'd32: begin mode_cur = 2'd3; depth_ok = 1'b1; len_div = clen_next >> 2; end
            default: begin mode_cur = 2'd0; depth_ok = 1'b0; len_div = '0; end
        endcase
        if (!done) begin
            unique case (ph)
                PH_RIFF, PH_WAVE, PH_CID: begin
                    tag = tag_next;
                    cnt = cnt1;
                    if (cnt1 >= 32'd4) begin
                        cnt = '0;
                        if (ph == PH_RIFF) begin
                            if (tag_next != TAG_RIFF) begin
                                finish = 1'b1; status = ST_BAD_RIFF;
                            end else ph = PH_RSIZE;
                        end else if (ph == PH_WAVE) begin
                            if (tag_next != TAG_WAVE) begin
                                finish = 1'b1; status = ST_BAD_WAVE;
                            end else ph = PH_CID;
                        end else begin
                            clen = '0; ph = PH_CSIZE;
                        end
                    end
                end
                PH_RSIZE: begin
                    cnt = cnt1;
                    if (cnt1 >= 32'd4) begin
                        cnt = '0; tag = '0; ph = PH_WAVE;
                    end
                end
                PH_CSIZE: begin
                    clen = clen_next;
                    cnt = cnt1;
                    if (cnt1 >= 32'd4) begin
                        cnt = '0;
                        if (tag == TAG_FMT) begin
                            if (clen_next < 32'd16) begin
                                finish = 1'b1; status = ST_SHORT_FMT;
                            end else begin
                                fseen = 1'b1; ph = PH_FMT;
                            end
                        end else if (tag == TAG_DATA) begin
                            if (!fseen) begin
                                finish = 1'b1; status = ST_NO_FMT;
                            end else if (!depth_ok) begin
                                finish = 1'b1; status = ST_BAD_DEPTH;
                            end else if (mode_cur == 2'd3 && fmt != FMT_PCM &&
                                         fmt != FMT_FLT && fmt != FMT_EXT) begin
                                finish = 1'b1; status = ST_BAD_FMT32;
                            end else begin
                                left = len_div;
                                if (len_div == '0) begin
                                    finish = 1'b1; status = ST_NO_DATA;
                                end else begin
                                    gath = '0; gidx = '0; ph = PH_DATA;
                                end
                            end
                        end else if (clen_next == '0) begin
                            tag = '0; ph = PH_CID;
                        end else begin
                            ph = PH_SKIP;
                        end
                    end
                end
                PH_FMT, PH_SKIP: begin
                    if (ph == PH_FMT) begin
                        unique case (cnt)
                            32'd0:  fmt[7:0]    = b;
                            32'd1:  fmt[15:8]   = b;
                            32'd2:  chan[7:0]   = b;
                            32'd3:  chan[15:8]  = b;
                            32'd4:  rate[7:0]   = b;
                            32'd5:  rate[15:8]  = b;
                            32'd6:  rate[23:16] = b;
                            32'd7:  rate[31:24] = b;
                            32'd14: depth[7:0]  = b;
                            32'd15: depth[15:8] = b;
                            default: ;
                        endcase
                    end
                    cnt = cnt1;
                    if (cnt1 >= clen) begin
                        cnt = '0; tag = '0;
                        ph = clen[0] ? PH_PAD : PH_CID;
                    end
                end
                PH_PAD: begin
                    cnt = '0; tag = '0; ph = PH_CID;
                end
                PH_DATA: begin
                    gath = gath | (32'(b) << {gidx, 3'b000});
                    if (gidx >= mode_cur) begin
                        have = 1'b1;
                        conv_req.valid    = 1'b1;
                        conv_req.gather   = gath;
                        conv_req.mode     = mode_cur;
                        conv_req.is_float = (fmt == FMT_FLT);
                        gath = '0; gidx = '0;
                        left = left - 32'd1;
                        if (left == '0) begin
                            finish = 1'b1; status = ST_OK;
                        end
                    end else begin
                        gidx = gidx + 2'd1;
                    end
                end
                default: begin
                    finish = 1'b1; status = ST_NO_DATA;
                end
            endcase
            // early end of file: status depends on where parsing stopped
            if (!finish && i_in.payload.file_end) begin
                finish = 1'b1;
                if (ph == PH_RIFF) status = ST_BAD_RIFF;
                else if (ph == PH_RSIZE || ph == PH_WAVE) status = ST_BAD_WAVE;
                else if (ph == PH_DATA) status = ST_OK;
                else status = ST_NO_DATA;
            end
            if (finish) done = 1'b1;
        end
        conv_req.last = finish;
        n_phase = ph; n_cnt = cnt; n_tag = tag; n_clen = clen; n_fmt = fmt;
        n_chan = chan; n_rate = rate; n_depth = depth; n_fseen = fseen;
        n_gath = gath; n_gidx = gidx; n_left = left; n_done = done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_RIFF; r_cnt <= '0; r_tag <= '0; r_clen <= '0;
            r_fmt <= '0; r_chan <= '0; r_rate <= '0; r_depth <= '0;
            r_fseen <= 1'b0; r_gath <= '0; r_gidx <= '0; r_left <= '0;
            r_done <= 1'b0; r_ovalid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase <= n_phase; r_cnt <= n_cnt; r_tag <= n_tag;
                r_clen <= n_clen; r_fmt <= n_fmt; r_chan <= n_chan;
                r_rate <= n_rate; r_depth <= n_depth; r_fseen <= n_fseen;
                r_gath <= n_gath; r_gidx <= n_gidx; r_left <= n_left;
                r_done <= n_done;
            end
            if (i_in.ready) begin
                r_ovalid <= accept && (have || finish);
            end
        end
    end

    // result payload: sample and captured header fields
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out.sample        <= have ? conv_smp : 16'd0;
            r_out.sample_valid  <= have;
            r_out.run_last      <= finish;
            r_out.status        <= status;
            r_out.rate_hz       <= n_rate;
            r_out.depth_bits    <= n_depth;
            r_out.channel_count <= n_chan;
        end
    end
endmodule
